FILE: rtl/core/sprd_pkg.sv
// Package for the serial PROM string deframer.
// Holds the phase and result kind codes and the structs shared by the core modules.
// No dependencies.
`timescale 1ns / 1ps

package sprd_pkg;

    localparam int unsigned PREAMBLE_W = 16;
    localparam int unsigned LENGTH_W   = 8;
    localparam int unsigned CFG_W      = 16;

    localparam logic [2:0] DONT_CARE_BITS = 3'd7;
    localparam logic [2:0] LAST_BIT       = 3'd7;
    localparam logic [7:0] STOP_BYTE      = 8'h00;

    localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET = 16'd1024;
    localparam logic [LENGTH_W-1:0]   LENGTH_RESET   = 8'd64;

    // configuration register indexes
    localparam logic REG_MAX_PREAMBLE = 1'b0;
    localparam logic REG_MAX_LENGTH   = 1'b1;

    // input command codes
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BIT   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PREAMBLE,
        PH_SKIP,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_STOP,
        KIND_NO_STOP,
        KIND_NO_START
    } kind_t;

    typedef struct packed {
        logic [PREAMBLE_W-1:0] preamble_limit;
        logic [LENGTH_W-1:0]   max_string_length;
    } limits_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [7:0] char_count;
        logic       last;
    } result_t;

endpackage

FILE: rtl/core/sprd_step.sv
// Per-word deframing step: phase, preamble count, bit count, byte shifter, index.
// Depends on sprd_pkg for the phase and kind codes and the limit/result structs.
`timescale 1ns / 1ps

module sprd_step
    import sprd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  logic    command,
    input  logic    data_bit,
    input  limits_t limits,
    output logic    res_valid,
    output result_t res,
    output phase_t  phase
);

    phase_t                phase_reg, phase_next;
    logic [PREAMBLE_W-1:0] preamble_count_reg, preamble_count_next;
    logic [2:0]            bit_count_reg, bit_count_next;
    logic [7:0]            shift_byte_reg, shift_byte_next;
    logic [7:0]            char_index_reg, char_index_next;

    logic [PREAMBLE_W-1:0] preamble_inc;
    logic [7:0]            shifted;
    logic                  at_limit;
    logic                  inc_at_limit;
    logic                  byte_full;
    logic                  length_hit;

    assign preamble_inc = preamble_count_reg + PREAMBLE_W'(1);
    assign shifted      = shift_byte_reg | (8'(data_bit) << bit_count_reg);
    assign at_limit     = preamble_count_reg >= limits.preamble_limit;
    assign inc_at_limit = preamble_inc >= limits.preamble_limit;
    assign byte_full    = bit_count_reg == LAST_BIT;
    assign length_hit   = char_index_reg == limits.max_string_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            preamble_count_reg <= '0;
            bit_count_reg      <= '0;
            shift_byte_reg     <= '0;
            char_index_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            preamble_count_reg <= preamble_count_next;
            bit_count_reg      <= bit_count_next;
            shift_byte_reg     <= shift_byte_next;
            char_index_reg     <= char_index_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next          = phase_reg;
        preamble_count_next = preamble_count_reg;
        bit_count_next      = bit_count_reg;
        shift_byte_next     = shift_byte_reg;
        char_index_next     = char_index_reg;
        if (command == CMD_BEGIN)
        begin
            phase_next          = PH_PREAMBLE;
            preamble_count_next = '0;
            bit_count_next      = '0;
            shift_byte_next     = '0;
            char_index_next     = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_PREAMBLE:
                begin
                    priority if (at_limit)
                        phase_next = PH_IDLE;
                    else if (!data_bit)
                    begin
                        phase_next     = PH_SKIP;
                        bit_count_next = '0;
                    end
                    else
                    begin
                        preamble_count_next = preamble_inc;
                        if (inc_at_limit)
                            phase_next = PH_IDLE;
                    end
                end
                PH_SKIP:
                begin
                    bit_count_next = bit_count_reg + 3'd1;
                    if (bit_count_next == DONT_CARE_BITS)
                    begin
                        bit_count_next  = '0;
                        shift_byte_next = '0;
                        phase_next      = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    bit_count_next  = bit_count_reg + 3'd1;
                    shift_byte_next = shifted;
                    if (byte_full)
                    begin
                        shift_byte_next = '0;
                        priority if (length_hit || shifted == STOP_BYTE)
                            phase_next = PH_IDLE;
                        else
                            char_index_next = char_index_reg + 8'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result for this word
    always_comb
    begin
        res_valid      = 1'b0;
        res.kind       = KIND_CHAR;
        res.byte_value = '0;
        res.byte_index = '0;
        res.char_count = '0;
        res.last       = 1'b0;
        if (command == CMD_BIT)
        begin
            unique case (phase_reg)
                PH_PREAMBLE:
                begin
                    if (at_limit || (data_bit && inc_at_limit))
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_NO_START;
                        res.last  = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    if (byte_full)
                    begin
                        res_valid      = 1'b1;
                        res.byte_index = char_index_reg;
                        priority if (length_hit)
                        begin
                            res.kind       = KIND_NO_STOP;
                            res.char_count = char_index_reg;
                            res.last       = 1'b1;
                        end
                        else if (shifted == STOP_BYTE)
                        begin
                            res.kind       = KIND_STOP;
                            res.char_count = char_index_reg;
                            res.last       = 1'b1;
                        end
                        else
                            res.byte_value = shifted;
                    end
                end
                PH_IDLE, PH_SKIP:
                begin
                    res_valid = 1'b0;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    assign phase = phase_reg;

endmodule

FILE: rtl/core/sprd_out_stage.sv
// Output register for deframer results, with the stall toward the input side.
// Depends on sprd_pkg for the result struct.
`timescale 1ns / 1ps

module sprd_out_stage
    import sprd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    out_stall,
    output logic    room,
    output logic    out_valid,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // a held word that is being taken frees the slot in the same cycle
    assign room = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: rtl/core/serial_prom_string_deframer_core.sv
// Serial PROM string deframer, top level: limit registers, step logic, output register.
// Depends on sprd_pkg, sprd_step and sprd_out_stage.
//
// Usage:
//   Input channel (in_valid/in_stall, command, data_bit): a command of 0 starts a
//   read, a command of 1 carries one sampled PROM data bit. Preamble ones are
//   skipped up to the preamble limit, the start bit is followed by 7 ignored bits,
//   then bytes are built LSB first and streamed out one result word per byte.
//   Output channel (out_valid/out_stall, kind, byte_value, byte_index,
//   char_count, last): at most one word per input word, last set on the word that
//   ends the read.
//   Throughput is one input word per cycle while in_stall is low; a result is on the
//   output in the cycle after its input word is taken, via the single output register.
//   While the output holds a word and out_stall is high, in_stall is raised; a
//   held word that is taken frees the register in the same cycle.
//   Reset clears the read state to idle, empties the output register and loads
//   a preamble limit of 1024 and max_string_length = 64. The user must write limits
//   via wr_en/wr_index/wr_data only while the block is idle; the block has no check.
`timescale 1ns / 1ps

module serial_prom_string_deframer_core
    import sprd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [CFG_W-1:0] wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             command,
    input  logic             data_bit,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       byte_value,
    output logic [7:0]       byte_index,
    output logic [7:0]       char_count,
    output logic             last
);

    limits_t limits_reg;
    logic    room;
    logic    in_accept;
    logic    res_valid;
    result_t step_res;
    result_t out_res;
    phase_t  phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.preamble_limit    <= PREAMBLE_RESET;
            limits_reg.max_string_length <= LENGTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MAX_PREAMBLE: limits_reg.preamble_limit <= wr_data[PREAMBLE_W-1:0];
                REG_MAX_LENGTH:   limits_reg.max_string_length <= wr_data[LENGTH_W-1:0];
                default:          limits_reg <= limits_reg;
            endcase
        end
    end

    assign in_stall  = !room;
    assign in_accept = in_valid && room;

    sprd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .command   (command),
        .data_bit  (data_bit),
        .limits    (limits_reg),
        .res_valid (res_valid),
        .res       (step_res),
        .phase     (phase)
    );

    sprd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept && res_valid),
        .res_in    (step_res),
        .out_stall (out_stall),
        .room      (room),
        .out_valid (out_valid),
        .res_out   (out_res)
    );

    assign kind       = out_res.kind;
    assign byte_value = out_res.byte_value;
    assign byte_index = out_res.byte_index;
    assign char_count = out_res.char_count;
    assign last       = out_res.last;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with a free output register");

    a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (out_res.kind != KIND_CHAR)))
        else $error("last flag does not match result kind");

    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && res_valid && step_res.last) |=> (phase == PH_IDLE))
        else $error("read not idle after its final word");

    a_no_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.kind == KIND_NO_START) |->
            (out_res.byte_index == 8'd0 && out_res.char_count == 8'd0))
        else $error("no-start word carries index or count");

    a_word_from_active_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && res_valid) |-> (phase == PH_PREAMBLE || phase == PH_DATA))
        else $error("result produced outside preamble or data phase");

endmodule

FILE: bench/serial_prom_string_deframer_core_tb.sv
// Self-checking bench for serial_prom_string_deframer_core.
// Streams PROM bit words through a bursty driver, predicts each result word in-line
// and checks it at a stalling monitor. Depends on sprd_pkg and the core RTL.
`timescale 1ns / 1ps

module serial_prom_string_deframer_core_tb;

    import sprd_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 220;
    localparam int N_PHASES     = 5;
    localparam int SETTLE_TICKS = 4;

    typedef struct packed {
        logic cmd;
        logic din;
    } prom_word_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                wr_en = 1'b0;
    logic                wr_index = REG_MAX_PREAMBLE;
    logic [CFG_W-1:0]    wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                command = CMD_BIT;
    logic                data_bit = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          kind;
    logic [7:0]          byte_value;
    logic [7:0]          byte_index;
    logic [7:0]          char_count;
    logic                last;

    serial_prom_string_deframer_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .data_bit   (data_bit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .byte_value (byte_value),
        .byte_index (byte_index),
        .char_count (char_count),
        .last       (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // predicted deframer state and limits
    phase_t      rd_phase = PH_IDLE;
    logic [15:0] pre_cnt = '0;
    logic [2:0]  bit_cnt = '0;
    logic [7:0]  shift_q = '0;
    logic [7:0]  char_idx = '0;
    logic [15:0] lim_pre = PREAMBLE_RESET;
    logic [7:0]  lim_len = LENGTH_RESET;

    prom_word_t  pending_words[$];
    result_t     expected_results[$];

    int          n_queued = 0;
    int          n_words_in = 0;
    int          n_in_stalls = 0;
    int          n_results = 0;
    int          n_mismatches = 0;
    int          kind_seen[4] = '{0, 0, 0, 0};

    logic [15:0] pre_set[N_PHASES] = '{16'd3, 16'd65535, 16'd1, 16'd16, 16'd300};
    logic [7:0]  len_set[N_PHASES] = '{8'd4, 8'd255, 8'd1, 8'd2, 8'd20};

    function automatic result_t make_result(kind_t k, logic [7:0] value, logic [7:0] idx,
                                            logic [7:0] count);
        result_t r;
        r.kind = k;
        r.byte_value = value;
        r.byte_index = idx;
        r.char_count = count;
        r.last = (k != KIND_CHAR);
        return r;
    endfunction

    // Advance the predicted deframer by one word; return 1 when it yields a result.
    function automatic bit deframe_bit(input logic cmd, input logic din, output result_t res);
        logic       full;
        logic [7:0] value;
        logic [7:0] idx;
        res = '0;
        if (cmd == CMD_BEGIN)
        begin
            rd_phase = PH_PREAMBLE;
            pre_cnt = '0;
            bit_cnt = '0;
            shift_q = '0;
            char_idx = '0;
            return 1'b0;
        end
        case (rd_phase)
            PH_PREAMBLE:
            begin
                // a zero limit fails on the first bit, whatever its level
                if (pre_cnt >= lim_pre)
                begin
                    rd_phase = PH_IDLE;
                    res = make_result(KIND_NO_START, 8'h00, 8'h00, 8'h00);
                    return 1'b1;
                end
                if (din == 1'b0)
                begin
                    rd_phase = PH_SKIP;
                    bit_cnt = '0;
                    return 1'b0;
                end
                pre_cnt = pre_cnt + 16'd1;
                if (pre_cnt >= lim_pre)
                begin
                    rd_phase = PH_IDLE;
                    res = make_result(KIND_NO_START, 8'h00, 8'h00, 8'h00);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_SKIP:
            begin
                bit_cnt = bit_cnt + 3'd1;
                if (bit_cnt == DONT_CARE_BITS)
                begin
                    bit_cnt = '0;
                    shift_q = '0;
                    rd_phase = PH_DATA;
                end
                return 1'b0;
            end
            PH_DATA:
            begin
                shift_q[bit_cnt] = din;
                full = (bit_cnt == LAST_BIT);
                bit_cnt = bit_cnt + 3'd1;
                if (!full)
                    return 1'b0;
                value = shift_q;
                idx = char_idx;
                shift_q = '0;
                // the length limit wins even over a stop byte
                if (idx == lim_len)
                begin
                    rd_phase = PH_IDLE;
                    res = make_result(KIND_NO_STOP, 8'h00, idx, idx);
                    return 1'b1;
                end
                if (value == STOP_BYTE)
                begin
                    rd_phase = PH_IDLE;
                    res = make_result(KIND_STOP, 8'h00, idx, idx);
                    return 1'b1;
                end
                char_idx = char_idx + 8'd1;
                res = make_result(KIND_CHAR, value, idx, 8'h00);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic push_word(logic cmd, logic din);
        prom_word_t w;
        w.cmd = cmd;
        w.din = din;
        pending_words.push_back(w);
        n_queued++;
    endtask

    task automatic push_byte(logic [7:0] value);
        for (int i = 0; i < 8; i++)
            push_word(CMD_BIT, value[i]);
    endtask

    task automatic push_preamble_start();
        push_word(CMD_BIT, 1'b0);
        repeat (7) push_word(CMD_BIT, 1'($urandom_range(0, 1)));
    endtask

    // One read with random content: mostly well formed, some run-on or cut short.
    task automatic queue_read();
        int n_ones;
        int n_bytes;
        int tail;
        push_word(CMD_BEGIN, 1'($urandom_range(0, 1)));
        n_ones = $urandom_range(0, 6);
        if ($urandom_range(0, 99) < 15 && lim_pre <= 400)
            n_ones = lim_pre;
        repeat (n_ones) push_word(CMD_BIT, 1'b1);
        if (n_ones >= lim_pre)
            return;
        push_preamble_start();
        n_bytes = $urandom_range(0, 5);
        repeat (n_bytes) push_byte(8'($urandom_range(1, 255)));
        tail = $urandom_range(0, 99);
        if (tail < 70)
            push_byte(STOP_BYTE);
        else if (tail < 85)
        begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(1, 255)));
            push_byte(STOP_BYTE);
        end
        else
            repeat ($urandom_range(0, 12)) push_word(CMD_BIT, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 10))
            push_word(($urandom_range(0, 6) != 0) ? CMD_BIT : CMD_BEGIN,
                      1'($urandom_range(0, 1)));
    endtask

    // Hold until no word is waiting on either side, then let the pipe settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic set_limits(logic [15:0] pre, logic [7:0] len);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_MAX_PREAMBLE;
        wr_data <= pre;
        lim_pre = pre;
        @(posedge clk);
        wr_index <= REG_MAX_LENGTH;
        wr_data <= {8'h00, len};
        lim_len = len;
        @(posedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            n_mismatches++;
        end
    endtask

    // Driver: bursts of words separated by random gaps.
    int         burst_left = 0;
    int         gap_left = 0;
    bit         drv_free;
    result_t    drv_res;
    prom_word_t drv_word;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            drv_free = !in_valid;
            if (in_valid && in_stall)
                n_in_stalls++;
            if (in_valid && !in_stall)
            begin
                if (deframe_bit(command, data_bit, drv_res))
                    expected_results.push_back(drv_res);
                n_words_in++;
                drv_free = 1'b1;
            end
            if (drv_free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    drv_word = pending_words.pop_front();
                    command <= drv_word.cmd;
                    data_bit <= drv_word.din;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off mid-run.
    rx_mode_t rx_mode = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && n_words_in >= 300)
            begin
                hold_left = 150;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   out_stall <= 1'b0;
                    RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    default:   out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Monitor: compare each taken result word with the oldest prediction.
    result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word: kind %0d value %0d index %0d count %0d",
                       kind, byte_value, byte_index, char_count);
                n_mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                kind_seen[want.kind]++;
                check_field("kind", 8'(want.kind), 8'(kind));
                check_field("byte_value", want.byte_value, byte_value);
                check_field("byte_index", want.byte_index, byte_index);
                check_field("char_count", want.char_count, char_count);
                check_field("last", 8'(want.last), 8'(last));
            end
        end
    end

    // Watchdog: end the run if no word moves for too long.
    int quiet = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $error("no word moved for %0d cycles", quiet);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limits: bits while idle, restart mid-preamble, empty string
        push_word(CMD_BIT, 1'b1);
        push_word(CMD_BIT, 1'b0);
        push_word(CMD_BEGIN, 1'b1);
        push_word(CMD_BIT, 1'b1);
        push_word(CMD_BEGIN, 1'b0);
        push_word(CMD_BIT, 1'b1);
        push_preamble_start();
        push_byte(STOP_BYTE);
        wait_idle();

        // preamble limit of one, bit after the end, zero length limit on a zero byte
        set_limits(16'd1, 8'd0);
        push_word(CMD_BEGIN, 1'b0);
        push_word(CMD_BIT, 1'b1);
        push_word(CMD_BIT, 1'b0);
        push_word(CMD_BEGIN, 1'b1);
        push_preamble_start();
        push_byte(STOP_BYTE);
        wait_idle();

        // zero preamble limit fails even on a start bit
        set_limits(16'd0, 8'd255);
        push_word(CMD_BEGIN, 1'b1);
        push_word(CMD_BIT, 1'b0);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_limits(pre_set[p], len_set[p]);
            n_queued = 0;
            while (n_queued < PHASE_WORDS)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    queue_noise();
                    2:
                        repeat ($urandom_range(1, 4))
                            push_word(CMD_BIT, 1'($urandom_range(0, 1)));
                    default: queue_read();
                endcase
            end
            wait_idle();
        end

        if (expected_results.size() != 0)
        begin
            $error("%0d predicted result words never arrived", expected_results.size());
            n_mismatches++;
        end
        $display("Run covered %0d input words (%0d input stall cycles) and %0d result words:",
                 n_words_in, n_in_stalls, n_results);
        $display("  %0d chars, %0d stop-byte ends, %0d length-limit ends, %0d no-start fails",
                 kind_seen[KIND_CHAR], kind_seen[KIND_STOP], kind_seen[KIND_NO_STOP],
                 kind_seen[KIND_NO_START]);
        if (n_mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
